[sv/scwd_pkg.sv]
// Package for the serial command window decoder.
// Holds event codes, command characters and the decode result type.
// No dependencies.
`timescale 1ns / 1ps

package scwd_pkg;

    // Depth of the received-byte window and the width of its fill count.
    localparam int unsigned WinLen = 6;
    localparam int unsigned SeenW  = 3;

    // Command characters.
    localparam logic [7:0] ChS_LO = 8'h73; // 's'
    localparam logic [7:0] ChD_LO = 8'h64; // 'd'
    localparam logic [7:0] ChT_UP = 8'h54; // 'T'
    localparam logic [7:0] ChC_UP = 8'h43; // 'C'
    localparam logic [7:0] ChD_UP = 8'h44; // 'D'
    localparam logic [7:0] ChR_UP = 8'h52; // 'R'
    localparam logic [7:0] ChS_UP = 8'h53; // 'S'
    localparam logic [7:0] ChT_LO = 8'h74; // 't'

    // Kind of an input item.
    localparam logic KindByte = 1'b0;
    localparam logic KindTick = 1'b1;

    // Event codes carried with each result item.
    typedef enum logic [2:0] {
        EV_ECHO  = 3'd0,
        EV_TIME  = 3'd1,
        EV_DUMP  = 3'd2,
        EV_LIST  = 3'd3,
        EV_RESET = 3'd4
    } t_event;

    // Outcome of decoding one input item.
    typedef struct packed {
        logic        valid;  // the item causes result items
        t_event      ev;
        logic        single; // one result item, else four bytes of word
        logic [31:0] word;   // bytes to send, lowest first; zero for single
    } t_result;

endpackage

[sv/scwd_core.sv]
// Window, byte count and timestamp state with the command decoder.
// Depends on scwd_pkg.
`timescale 1ns / 1ps

module scwd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,  // commit the presented item
    input  logic                i_kind,
    input  logic [7:0]          i_byte,
    output scwd_pkg::t_result   o_res
);

    logic [7:0]                  r_win [scwd_pkg::WinLen];
    logic [scwd_pkg::SeenW-1:0]  r_seen;
    logic [31:0]                 r_stamp;
    logic                        r_running;

    logic [7:0]                  w [scwd_pkg::WinLen];
    logic [scwd_pkg::SeenW-1:0]  seen_inc;
    logic                        full;
    logic                        m_dump, m_sync, m_time, m_list, m_rst, any_match;
    logic [31:0]                 sync_word;

    // Window as it stands after shifting in the presented byte.
    always_comb begin
        for (int i = 0; i < scwd_pkg::WinLen - 1; i++) begin
            w[i] = r_win[i+1];
        end
        w[scwd_pkg::WinLen-1] = i_byte;
    end

    assign seen_inc = (r_seen == scwd_pkg::SeenW'(scwd_pkg::WinLen)) ? r_seen
                                                                     : r_seen + 1'b1;
    assign full     = (seen_inc == scwd_pkg::SeenW'(scwd_pkg::WinLen));
    assign sync_word = {w[5], w[4], w[3], w[2]};

    // Command matches on the oldest bytes, in priority order.
    always_comb begin
        logic byte_full;
        byte_full = (i_kind == scwd_pkg::KindByte) && full;
        m_dump = byte_full && w[0] == scwd_pkg::ChS_LO && w[1] == scwd_pkg::ChD_LO;
        m_sync = byte_full && !m_dump
                 && w[0] == scwd_pkg::ChT_UP && w[1] == scwd_pkg::ChC_UP;
        m_time = byte_full && !m_dump && !m_sync
                 && w[0] == scwd_pkg::ChC_UP && w[1] == scwd_pkg::ChT_UP;
        m_list = byte_full && !m_dump && !m_sync && !m_time
                 && w[0] == scwd_pkg::ChD_UP && w[1] == scwd_pkg::ChS_LO
                 && w[2] == scwd_pkg::ChT_UP;
        m_rst  = byte_full && !m_dump && !m_sync && !m_time && !m_list
                 && w[0] == scwd_pkg::ChR_UP && w[1] == scwd_pkg::ChS_UP
                 && w[2] == scwd_pkg::ChT_LO;
        any_match = m_dump || m_sync || m_time || m_list || m_rst;
    end

    // Result of the presented item.
    always_comb begin
        o_res.valid  = any_match;
        o_res.single = !(m_sync || m_time);
        o_res.word   = 32'd0;
        o_res.ev     = scwd_pkg::EV_DUMP;
        if (m_sync) begin
            o_res.ev   = scwd_pkg::EV_ECHO;
            o_res.word = sync_word;
        end else if (m_time) begin
            o_res.ev   = scwd_pkg::EV_TIME;
            o_res.word = r_stamp;
        end else if (m_list) begin
            o_res.ev   = scwd_pkg::EV_LIST;
        end else if (m_rst) begin
            o_res.ev   = scwd_pkg::EV_RESET;
        end
    end

    // State update when the item is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scwd_pkg::WinLen; i++) begin
                r_win[i] <= 8'd0;
            end
            r_seen    <= '0;
            r_stamp   <= 32'd0;
            r_running <= 1'b0;
        end else if (i_take) begin
            if (i_kind == scwd_pkg::KindTick) begin
                if (r_running) begin
                    r_stamp <= r_stamp + 32'd1;
                end
            end else if (any_match) begin
                for (int i = 0; i < scwd_pkg::WinLen; i++) begin
                    r_win[i] <= 8'd0;
                end
                r_seen <= '0;
                if (m_sync) begin
                    r_stamp   <= sync_word;
                    r_running <= 1'b1;
                end
            end else begin
                for (int i = 0; i < scwd_pkg::WinLen; i++) begin
                    r_win[i] <= w[i];
                end
                r_seen <= seen_inc;
            end
        end
    end

endmodule

[sv/serial_command_window_decoder.sv]
// Top level of the serial command window decoder: input register,
// decoder core and transmit register. Depends on scwd_pkg and scwd_core.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata = rx_byte[7:0]; tuser = cmd (1 = tick)
//  m_axis   | out       | tdata = out_byte[7:0]; tuser = event_res[2:0]; tlast = last
//
// An item passes the input register and is decoded in the next cycle.
// Ticks and bytes that match no command are committed back to back. A matched
// command loads the transmit register; while m_axis_tready is high it sends
// one result item per cycle: four for a sync echo or time report, one otherwise.
// A command item waits in the input register until the transmit register is
// free; synchronous active-low reset clears valid flags, r_out_idx and core state.
`timescale 1ns / 1ps

module serial_command_window_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0] s_axis_tuser,  // [0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic [2:0] m_axis_tuser,  // [2:0] event_res
    output logic       m_axis_tlast
);

    logic              r_in_valid;
    logic              r_in_kind;
    logic [7:0]        r_in_byte;

    logic              r_out_valid;
    scwd_pkg::t_event  r_out_ev;
    logic              r_out_single;
    logic [31:0]       r_out_word;
    logic [1:0]        r_out_idx;

    scwd_pkg::t_result res;
    logic              out_last;
    logic              out_pop;
    logic              out_free;
    logic              take;

    // Transmit side status.
    assign out_last = r_out_single || (r_out_idx == 2'd3);
    assign out_pop  = r_out_valid && m_axis_tready;
    assign out_free = !r_out_valid || (out_pop && out_last);

    // Commit the held item unless it has results and the transmitter is busy.
    assign take          = r_in_valid && (!res.valid || out_free);
    assign s_axis_tready = !r_in_valid || take;

    scwd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    // Transmit register: shifts out one byte per accepted result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= 2'd0;
        end else if (take && res.valid) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= 2'd0;
        end else if (out_pop) begin
            r_out_valid <= !out_last;
            r_out_idx   <= r_out_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out_ev     <= res.ev;
            r_out_single <= res.single;
            r_out_word   <= res.word;
        end else if (out_pop) begin
            r_out_word   <= {8'd0, r_out_word[31:8]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word[7:0];
    assign m_axis_tuser  = r_out_ev;
    assign m_axis_tlast  = out_last;

endmodule
